@@ hw/rtl/srws_pkg.sv @@
// srws_pkg: widths, codes and types shared by the spectral window smoother.
// No dependencies; compiled before every other file of the block.
`default_nettype none

package srws_pkg;

   localparam int IDX_W     = 12;   // bin index
   localparam int AMP_W     = 24;   // amplitude, Q12.12
   localparam int ANG_W     = 16;   // angle, Q2.13
   localparam int CNT_W     = 13;   // bins in use, window count, scan index
   localparam int K_W       = 16;   // smoothing factor, Q4.12
   localparam int Q12_SH    = 12;   // shift that gives one in Q4.12
   localparam int PROD_W    = 29;   // j*k and i*k
   localparam int ACC_AMP_W = AMP_W + CNT_W;
   localparam int ACC_ANG_W = ANG_W + CNT_W;
   localparam int DIV_W     = ACC_AMP_W;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTHING = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BINS      = 2'd1;

   localparam logic [K_W-1:0]   K_RESET    = 16'd4915;
   localparam logic [CNT_W-1:0] BINS_RESET = 13'd4096;

   typedef struct packed {
      logic [AMP_W-1:0] amp;
      logic [ANG_W-1:0] ang;
   } bin_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [CNT_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

@@ hw/rtl/srws_div.sv @@
// srws_div: restoring divider, one quotient bit per cycle, unsigned.
// Depends on srws_pkg for widths and the request/response structs.
`default_nettype none

module srws_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire srws_pkg::div_req_type req,
   output srws_pkg::div_rsp_type      rsp
);
   import srws_pkg::*;

   localparam int CW = $clog2(DIV_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] dvs_ff, dvs_in;

   logic [CNT_W:0]   sh;
   logic [CNT_W:0]   diff;
   logic             ge;

   always_comb begin
      sh   = {rem_ff, quo_ff[DIV_W-1]};
      ge   = sh >= {1'b0, dvs_ff};
      diff = sh - {1'b0, dvs_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_W-2:0], ge};
         rem_in = ge ? diff[CNT_W-1:0] : sh[CNT_W-1:0];
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

`default_nettype wire

@@ hw/rtl/spectral_ratio_window_smoother_top.sv @@
// Spectral ratio window smoother, top level: bin store, window scan, divide.
// Depends on srws_pkg and srws_div.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------------------
//  req     | in        | req_valid / req_ready   | op, bin_index, amplitude_in, angle_in
//  rsp     | out       | rsp_valid / rsp_ready   | smoothed_amplitude/_angle, count, valid
//  csr     | in        | csr_valid / csr_ready   | csr_index, csr_data
//
// A write word goes straight into the bin memory.
// A query word holds the block from its accepting edge (n = bins in use, capped at MAX_BINS):
// a scan of bins 1 to n - 2, reading one bin a cycle from the bin memory, a drain step for the
// last read, a check step for an empty window, then the shared bit-serial divider twice
// (start, 37 quotient bits, hand-over each time), and a step to load the output register.
// A rejected query goes straight to loading the output register.
// Reset clears control only; the bin memory is not cleared and needs no pass.
// A finished result sits in the output register; writes are still taken while
// it waits, and a query only stalls at its very end until the slot is free.
`default_nettype none

module spectral_ratio_window_smoother_top #(
   parameter int MAX_BINS = 4096
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,

   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic                                 req_op,
   input  wire logic [srws_pkg::IDX_W-1:0]           req_bin_index,
   input  wire logic [srws_pkg::AMP_W-1:0]           req_amplitude_in,
   input  wire logic signed [srws_pkg::ANG_W-1:0]    req_angle_in,

   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [srws_pkg::AMP_W-1:0]                rsp_smoothed_amplitude,
   output logic signed [srws_pkg::ANG_W-1:0]         rsp_smoothed_angle,
   output logic [srws_pkg::CNT_W-1:0]                rsp_window_count,
   output logic                                      rsp_valid_res,

   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [srws_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [srws_pkg::CSR_DAT_W-1:0]       csr_data
);
   import srws_pkg::*;

   localparam int AW = $clog2(MAX_BINS);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_DRAIN, ST_CHECK, ST_DIV_AMP, ST_DIV_ANG, ST_FINISH
   } state_type;

   // configuration
   logic [K_W-1:0]   csr_k_ff;
   logic [CNT_W-1:0] csr_bins_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_k_ff    <= K_RESET;
         csr_bins_ff <= BINS_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SMOOTHING: csr_k_ff    <= csr_data[K_W-1:0];
            CSR_BINS:      csr_bins_ff <= csr_data[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // bin memory: one write port (idle only), one registered read port (scan)
   bin_type         mem [MAX_BINS];
   bin_type         mem_rd_ff;
   logic            mem_we;
   logic [AW-1:0]   mem_wa;
   logic [AW-1:0]   mem_ra;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= {req_amplitude_in, req_angle_in};
   end

   always_ff @(posedge clock) begin
      mem_rd_ff <= mem[mem_ra];
   end

   // control and datapath registers
   state_type                   state_ff, state_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic [CNT_W-1:0]            n_ff, n_in;
   logic [PROD_W-1:0]           ik_ff, ik_in;
   logic [CNT_W-1:0]            j_ff, j_in;
   logic [PROD_W-1:0]           jk_ff, jk_in;
   logic                        tap_ff, tap_in;
   logic                        hit_ff, hit_in;
   logic [ACC_AMP_W-1:0]        amp_acc_ff, amp_acc_in;
   logic signed [ACC_ANG_W-1:0] ang_acc_ff, ang_acc_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        div_start_ff, div_start_in;
   logic [AMP_W-1:0]            res_amp_ff, res_amp_in;
   logic [ANG_W-1:0]            res_ang_ff, res_ang_in;
   logic                        res_ok_ff, res_ok_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [AMP_W-1:0]            rsp_amp_ff, rsp_amp_in;
   logic [ANG_W-1:0]            rsp_ang_ff, rsp_ang_in;
   logic [CNT_W-1:0]            rsp_cnt_ff, rsp_cnt_in;
   logic                        rsp_ok_ff, rsp_ok_in;

   logic [IDX_W+K_W-1:0] ik_prod;
   logic [CNT_W-1:0]     n_cap;
   logic                 req_acc;
   logic                 reject;
   logic                 ang_neg;
   logic [ACC_ANG_W-1:0] ang_mag;
   logic [ANG_W-1:0]     q_ang;

   div_req_type div_req;
   div_rsp_type div_rsp;

   srws_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign ik_prod   = req_bin_index * csr_k_ff;
   assign n_cap     = (32'(csr_bins_ff) > MAX_BINS) ? CNT_W'(MAX_BINS) : csr_bins_ff;
   assign reject    = (req_bin_index == '0) || (CNT_W'(req_bin_index) >= n_cap)
                      || (n_cap < CNT_W'(3));

   assign mem_wa = AW'(req_bin_index);
   assign mem_ra = AW'(j_ff);

   // angle mean: divide the magnitude, put the sign back (truncates toward zero)
   assign ang_neg = ang_acc_ff[ACC_ANG_W-1];
   assign ang_mag = ang_neg ? $unsigned(-ang_acc_ff) : $unsigned(ang_acc_ff);
   assign q_ang   = div_rsp.quotient[ANG_W-1:0];

   assign div_req.start    = div_start_ff;
   assign div_req.dividend = (state_ff == ST_DIV_ANG) ? DIV_W'(ang_mag) : DIV_W'(amp_acc_ff);
   assign div_req.divisor  = cnt_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      ik_in        = ik_ff;
      j_in         = j_ff;
      jk_in        = jk_ff;
      tap_in       = 1'b0;
      hit_in       = 1'b0;
      amp_acc_in   = amp_acc_ff;
      ang_acc_in   = ang_acc_ff;
      cnt_in       = cnt_ff;
      div_start_in = 1'b0;
      res_amp_in   = res_amp_ff;
      res_ang_in   = res_ang_ff;
      res_ok_in    = res_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_amp_in   = rsp_amp_ff;
      rsp_ang_in   = rsp_ang_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_ok_in    = rsp_ok_ff;
      mem_we       = 1'b0;

      // bin read in the previous cycle lands now
      if (tap_ff && hit_ff) begin
         amp_acc_in = amp_acc_ff + ACC_AMP_W'(mem_rd_ff.amp);
         ang_acc_in = ang_acc_ff + ACC_ANG_W'($signed(mem_rd_ff.ang));
         cnt_in     = cnt_ff + CNT_W'(1);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_op == OP_WRITE) begin
               mem_we = (32'(req_bin_index) < MAX_BINS);
            end else if (req_acc) begin
               idx_in     = req_bin_index;
               n_in       = n_cap;
               ik_in      = PROD_W'(ik_prod);
               j_in       = CNT_W'(1);
               jk_in      = PROD_W'(csr_k_ff);
               amp_acc_in = '0;
               ang_acc_in = '0;
               cnt_in     = '0;
               res_ok_in  = 1'b0;
               state_in   = reject ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            // i/k < j < i*k, scaled by 4096 on both sides
            hit_in = (PROD_W'({idx_ff, Q12_SH'(0)}) < jk_ff)
                     && (PROD_W'({j_ff, Q12_SH'(0)}) < ik_ff);
            tap_in = 1'b1;
            j_in   = j_ff + CNT_W'(1);
            jk_in  = jk_ff + PROD_W'(csr_k_ff);
            if ((CNT_W+1)'(j_ff) + (CNT_W+1)'(2) == (CNT_W+1)'(n_ff)) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (cnt_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               div_start_in = 1'b1;
               state_in     = ST_DIV_AMP;
            end
         end
         ST_DIV_AMP: begin
            if (div_rsp.done) begin
               res_amp_in   = div_rsp.quotient[AMP_W-1:0];
               div_start_in = 1'b1;
               state_in     = ST_DIV_ANG;
            end
         end
         ST_DIV_ANG: begin
            if (div_rsp.done) begin
               res_ang_in = ang_neg ? -q_ang : q_ang;
               res_ok_in  = 1'b1;
               state_in   = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_amp_in   = res_ok_ff ? res_amp_ff : '0;
               rsp_ang_in   = res_ok_ff ? res_ang_ff : '0;
               rsp_cnt_in   = res_ok_ff ? cnt_ff : '0;
               rsp_ok_in    = res_ok_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_ff       <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_ff       <= tap_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff     <= idx_in;
      n_ff       <= n_in;
      ik_ff      <= ik_in;
      j_ff       <= j_in;
      jk_ff      <= jk_in;
      hit_ff     <= hit_in;
      amp_acc_ff <= amp_acc_in;
      ang_acc_ff <= ang_acc_in;
      cnt_ff     <= cnt_in;
      res_amp_ff <= res_amp_in;
      res_ang_ff <= res_ang_in;
      res_ok_ff  <= res_ok_in;
      rsp_amp_ff <= rsp_amp_in;
      rsp_ang_ff <= rsp_ang_in;
      rsp_cnt_ff <= rsp_cnt_in;
      rsp_ok_ff  <= rsp_ok_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_smoothed_amplitude = rsp_amp_ff;
   assign rsp_smoothed_angle     = $signed(rsp_ang_ff);
   assign rsp_window_count       = rsp_cnt_ff;
   assign rsp_valid_res          = rsp_ok_ff;

endmodule

`default_nettype wire

@@ hw/rtl/srws_checker.sv @@
// srws_checker: port-level assertions for the spectral window smoother.
// Depends on srws_pkg; bound onto spectral_ratio_window_smoother_top below.
`default_nettype none

module srws_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic                              req_op,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [srws_pkg::AMP_W-1:0]        rsp_smoothed_amplitude,
   input wire logic signed [srws_pkg::ANG_W-1:0] rsp_smoothed_angle,
   input wire logic [srws_pkg::CNT_W-1:0]        rsp_window_count,
   input wire logic                              rsp_valid_res
);
   import srws_pkg::*;

   // a word held back by the sink stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   // an invalid result carries zeros throughout
   a_zero_res: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |->
         rsp_smoothed_amplitude == '0 && rsp_smoothed_angle == '0
         && rsp_window_count == '0)
      else $error("invalid result with non-zero fields");

   // a valid result averaged at least one bin
   a_count_nz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_res |-> rsp_window_count != '0)
      else $error("valid result with empty window");

   // a query occupies the block: no new word the cycle after
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op == OP_QUERY |=> !req_ready)
      else $error("word taken straight after a query");

   // nothing offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind spectral_ratio_window_smoother_top srws_checker u_srws_checker (
   .clock                  (clock),
   .reset                  (reset),
   .req_valid              (req_valid),
   .req_ready              (req_ready),
   .req_op                 (req_op),
   .rsp_valid              (rsp_valid),
   .rsp_ready              (rsp_ready),
   .rsp_smoothed_amplitude (rsp_smoothed_amplitude),
   .rsp_smoothed_angle     (rsp_smoothed_angle),
   .rsp_window_count       (rsp_window_count),
   .rsp_valid_res          (rsp_valid_res)
);

`default_nettype wire
